>>> hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// shared constants, types and helpers for the playfair digraph cipher
// ----------------------------------------------------------------------------
package pfc_pkg;

   localparam int SQ_SIZE    = 5;
   localparam int LETTER_W   = 5;
   localparam int IDX_W      = 3;
   localparam int KEY_ROW_W  = SQ_SIZE * LETTER_W;
   localparam int NUM_CELLS  = SQ_SIZE * SQ_SIZE;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int TDATA_W    = 16;

   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
   localparam logic [LETTER_W-1:0] CODE_Z = 5'd25;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SQ_SIZE - 1);

   // register indexes on the csr port
   typedef enum logic [IDX_W-1:0] {
      REG_KEY_ROW0 = 3'd0,
      REG_KEY_ROW1 = 3'd1,
      REG_KEY_ROW2 = 3'd2,
      REG_KEY_ROW3 = 3'd3,
      REG_KEY_ROW4 = 3'd4
   } csr_reg_type;

   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } cmd_type;

   // row, column, letter
   typedef logic [SQ_SIZE-1:0][SQ_SIZE-1:0][LETTER_W-1:0] key_sq_type;

   // square after reset: A..E / F..I,K / L..P / Q..U / V..Z
   localparam logic [KEY_ROW_W-1:0] KEY_ROW0_RESET = 25'd4294688;
   localparam logic [KEY_ROW_W-1:0] KEY_ROW1_RESET = 25'd10755269;
   localparam logic [KEY_ROW_W-1:0] KEY_ROW2_RESET = 25'd16201099;
   localparam logic [KEY_ROW_W-1:0] KEY_ROW3_RESET = 25'd21613104;
   localparam logic [KEY_ROW_W-1:0] KEY_ROW4_RESET = 25'd27025109;

   // stage 1: match vectors, row-major cell order
   typedef struct packed {
      logic                 dec;
      logic [NUM_CELLS-1:0] hit_a;
      logic [NUM_CELLS-1:0] hit_b;
   } s1_type;

   // stage 2: located coordinates
   typedef struct packed {
      logic             dec;
      logic             found;
      logic [IDX_W-1:0] ar;
      logic [IDX_W-1:0] ac;
      logic [IDX_W-1:0] br;
      logic [IDX_W-1:0] bc;
   } s2_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
      return (x == IDX_LAST) ? '0 : x + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
      return (x == '0) ? IDX_LAST : x - IDX_W'(1);
   endfunction

endpackage

>>> hw/rtl/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// playfair digraph cipher over a 5x5 key square held in csr registers
// ----------------------------------------------------------------------------
// throughput: one item per cycle while rsp_tready is high; three register
//   stages with per-stage valid bits, the 25-cell compare runs in parallel
//   in the first stage
// reset: synchronous, active high; clears all stage valid bits and loads the
//   default key square (A..Z without J, row-major)
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [4:0] first_letter, [9:5] second_letter, [10] pad_second, rest zero
   input  logic [pfc_pkg::TDATA_W-1:0]        req_tdata,
   // [0] cmd
   input  logic                               req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [4:0] out_first, [9:5] out_second, rest zero
   output logic [pfc_pkg::TDATA_W-1:0]        rsp_tdata,
   // [0] not_found
   output logic                               rsp_tuser,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int SQ = pfc_pkg::SQ_SIZE;
   localparam int LW = pfc_pkg::LETTER_W;
   localparam int IW = pfc_pkg::IDX_W;

   // ------------------------------------------------------------------------
   // key square registers
   // ------------------------------------------------------------------------
   pfc_pkg::key_sq_type key_sq_ff, key_sq_in;
   logic [IW-1:0]       csr_idx;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[IW+1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      key_sq_in = key_sq_ff;
      // writes beyond the last row are dropped
      if (csr_wr && (csr_idx < IW'(SQ))) begin
         key_sq_in[csr_idx] = csr_pwdata[pfc_pkg::KEY_ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_sq_ff[pfc_pkg::REG_KEY_ROW0] <= pfc_pkg::KEY_ROW0_RESET;
         key_sq_ff[pfc_pkg::REG_KEY_ROW1] <= pfc_pkg::KEY_ROW1_RESET;
         key_sq_ff[pfc_pkg::REG_KEY_ROW2] <= pfc_pkg::KEY_ROW2_RESET;
         key_sq_ff[pfc_pkg::REG_KEY_ROW3] <= pfc_pkg::KEY_ROW3_RESET;
         key_sq_ff[pfc_pkg::REG_KEY_ROW4] <= pfc_pkg::KEY_ROW4_RESET;
      end else begin
         key_sq_ff <= key_sq_in;
      end
   end

   // read back, zero beyond the last row
   always_comb begin
      csr_prdata = '0;
      if (csr_idx < IW'(SQ)) begin
         csr_prdata = pfc_pkg::CSR_DATA_W'(key_sq_ff[csr_idx]);
      end
   end

   // ------------------------------------------------------------------------
   // pipeline flow control: a stage takes a new item when empty or when
   // the stage after it is moving
   // ------------------------------------------------------------------------
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic ready1, ready2, ready3;

   assign ready3     = !v3_ff || rsp_tready;
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1;

   assign v1_in = ready1 ? req_tvalid : v1_ff;
   assign v2_in = ready2 ? v1_ff      : v2_ff;
   assign v3_in = ready3 ? v2_ff      : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: letter folding and parallel compare against every cell
   // ------------------------------------------------------------------------
   pfc_pkg::s1_type s1_ff, s1_in;
   logic [LW-1:0]   let_a, let_b;

   always_comb begin
      let_a = req_tdata[LW-1:0];
      let_b = req_tdata[2*LW-1:LW];
      // padding replaces the second letter before folding
      if (req_tdata[2*LW]) begin
         let_b = pfc_pkg::CODE_Z;
      end
      // J reads as I, so a J cell never matches
      if (let_a == pfc_pkg::CODE_J) begin
         let_a = pfc_pkg::CODE_I;
      end
      if (let_b == pfc_pkg::CODE_J) begin
         let_b = pfc_pkg::CODE_I;
      end

      s1_in     = s1_ff;
      s1_in.dec = (req_tuser == pfc_pkg::CMD_DECRYPT);
      for (int r = 0; r < SQ; r++) begin
         for (int c = 0; c < SQ; c++) begin
            s1_in.hit_a[r*SQ+c] = (key_sq_ff[r][c] == let_a);
            s1_in.hit_b[r*SQ+c] = (key_sq_ff[r][c] == let_b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && ready1) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: encode the hit vectors to row and column; a code present
   // more than once resolves to its last place in row-major order
   // ------------------------------------------------------------------------
   pfc_pkg::s2_type s2_ff, s2_in;

   always_comb begin
      s2_in       = '0;
      s2_in.dec   = s1_ff.dec;
      s2_in.found = (|s1_ff.hit_a) && (|s1_ff.hit_b);
      for (int r = 0; r < SQ; r++) begin
         for (int c = 0; c < SQ; c++) begin
            if (s1_ff.hit_a[r*SQ+c]) begin
               s2_in.ar = IW'(r);
               s2_in.ac = IW'(c);
            end
            if (s1_ff.hit_b[r*SQ+c]) begin
               s2_in.br = IW'(r);
               s2_in.bc = IW'(c);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff && ready2) begin
         s2_ff <= s2_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: apply the digraph rule and read the new letters
   // ------------------------------------------------------------------------
   logic [IW-1:0] r1, c1, r2, c2;
   logic [LW-1:0] out_first_in, out_second_in, out_first_ff, out_second_ff;
   logic          not_found_in, not_found_ff;

   always_comb begin
      r1 = s2_ff.ar;
      c1 = s2_ff.bc;
      r2 = s2_ff.br;
      c2 = s2_ff.ac;
      priority if (s2_ff.ac == s2_ff.bc) begin
         // same column, equal letters included: move down or up
         c1 = s2_ff.ac;
         c2 = s2_ff.bc;
         r1 = s2_ff.dec ? pfc_pkg::idx_dec(s2_ff.ar) : pfc_pkg::idx_inc(s2_ff.ar);
         r2 = s2_ff.dec ? pfc_pkg::idx_dec(s2_ff.br) : pfc_pkg::idx_inc(s2_ff.br);
      end else if (s2_ff.ar == s2_ff.br) begin
         // same row: move right or left
         r1 = s2_ff.ar;
         r2 = s2_ff.br;
         c1 = s2_ff.dec ? pfc_pkg::idx_dec(s2_ff.ac) : pfc_pkg::idx_inc(s2_ff.ac);
         c2 = s2_ff.dec ? pfc_pkg::idx_dec(s2_ff.bc) : pfc_pkg::idx_inc(s2_ff.bc);
      end else begin
         // rectangle: swap columns, keep rows (defaults above)
         r1 = s2_ff.ar;
      end

      not_found_in  = !s2_ff.found;
      out_first_in  = '0;
      out_second_in = '0;
      if (s2_ff.found) begin
         out_first_in  = key_sq_ff[r1][c1];
         out_second_in = key_sq_ff[r2][c2];
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && ready3) begin
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         not_found_ff  <= not_found_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = pfc_pkg::TDATA_W'({out_second_ff, out_first_ff});
   assign rsp_tuser  = not_found_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
   // a missing letter gives zero letters
   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("not_found item carries nonzero letters");

   // an empty output stage never blocks the input
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with output stage empty");

   // a stalled stage 2 item keeps its coordinates
   a_s2_hold : assert property (@(posedge clock) disable iff (reset)
      v2_ff && !ready3 |=> v2_ff && $stable(s2_ff))
      else $error("stage 2 item changed while stalled");

   // located coordinates stay inside the square
   a_s2_range : assert property (@(posedge clock) disable iff (reset)
      v2_ff && s2_ff.found |-> s2_ff.ar < IW'(SQ) && s2_ff.ac < IW'(SQ)
         && s2_ff.br < IW'(SQ) && s2_ff.bc < IW'(SQ))
      else $error("located coordinate outside the square");
`endif

endmodule
